// File: sv/ttb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared widths, command/status types and controller states for the
// triangle tangent basis block.
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int COORD_BITS  = 16;
    localparam int RESULT_BITS = 32;
    localparam int POS_FRAC    = 8;
    localparam int UV_FRAC     = 12;
    localparam int OUT_FRAC    = 16;
    localparam int QUOT_SHIFT  = OUT_FRAC + 2 * UV_FRAC - POS_FRAC - UV_FRAC;

    localparam int EDGE_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int DIVD_W  = SUM_W + QUOT_SHIFT;
    localparam int CNT_W   = $clog2(DIVD_W + 1);

    localparam int IN_DATA_W  = ((5 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((6 * RESULT_BITS + 7) / 8) * 8;

    // Multiplier schedule: seven product pairs, one product per cycle,
    // plus a final step to retire the last pair.
    localparam int MUL_STEPS = 14;
    localparam int N_COMP    = 6;

    localparam logic [1:0] CORNER_0 = 2'd0;
    localparam logic [1:0] CORNER_1 = 2'd1;
    localparam logic [1:0] CORNER_2 = 2'd2;

    typedef struct packed {
        logic             store;
        logic             store_idx;
        logic             tri_start;
        logic             mul_en;
        logic [3:0]       mul_step;
        logic             div_load;
        logic             div_step;
        logic             div_sat;
        logic [2:0]       comp;
        logic             out_load;
    } ttb_cmd_t;

    typedef struct packed {
        logic det_zero;
        logic out_free;
    } ttb_sts_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_DIVL = 6'b000100,
        S_DIV  = 6'b001000,
        S_SAT  = 6'b010000,
        S_OUT  = 6'b100000
    } ttb_state_t;

endpackage

// File: sv/ttb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_ctrl
// Sequencer: accepts corners, steps the shared multiplier, runs the divider once
// per output component unless the determinant is zero, and loads the output.
// ----------------------------------------------------------------------------
module ttb_ctrl
    import ttb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [1:0] s_axis_tuser,
    input  ttb_sts_t   sts,
    output ttb_cmd_t   cmd
);

    ttb_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       comp_reg, comp_next;
    logic             fire;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign fire          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        cmd        = '0;
        cmd.comp     = comp_reg;
        cmd.mul_step = cnt_reg[3:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (fire)
                begin
                    if (s_axis_tuser == CORNER_0 || s_axis_tuser == CORNER_1)
                    begin
                        cmd.store     = 1'b1;
                        cmd.store_idx = (s_axis_tuser == CORNER_1);
                    end
                    else if (s_axis_tuser == CORNER_2)
                    begin
                        cmd.tri_start = 1'b1;
                        cnt_next      = '0;
                        state_next    = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS))
                begin
                    cnt_next   = '0;
                    comp_next  = 3'd1;
                    state_next = sts.det_zero ? S_OUT : S_DIVL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIVL:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIVD_W - 1))
                begin
                    state_next = S_SAT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SAT:
            begin
                cmd.div_sat = 1'b1;
                if (comp_reg == 3'(N_COMP))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = S_DIVL;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

endmodule

// File: sv/ttb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_dp
// Datapath: corner storage, edge registers, one shared signed multiplier,
// a restoring divider with saturation, and the output register.
// ----------------------------------------------------------------------------
module ttb_dp
    import ttb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  ttb_cmd_t              cmd,
    output ttb_sts_t              sts,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser
);

    localparam int DEN_W = SUM_W;
    localparam logic [DIVD_W-1:0] MAXPOS_Q =
        DIVD_W'((65'd1 << (RESULT_BITS - 1)) - 65'd1);

    logic signed [COORD_BITS-1:0] in_pos [3];
    logic signed [COORD_BITS-1:0] in_tex [2];

    logic signed [COORD_BITS-1:0] pos_reg [2][3];
    logic signed [COORD_BITS-1:0] tex_reg [2][2];

    logic signed [EDGE_W-1:0] e0_reg [3];
    logic signed [EDGE_W-1:0] e1_reg [3];
    logic signed [EDGE_W-1:0] du0_reg, dv0_reg, du1_reg, dv1_reg;

    logic signed [EDGE_W-1:0] op_a, op_b;
    logic signed [PROD_W-1:0] prod_reg, first_reg;
    logic signed [SUM_W-1:0]  res_reg [7];
    logic [3:0]               prev_step;

    logic [DIVD_W-1:0]      dq_reg;
    logic [DEN_W-1:0]       rem_reg, dmag_reg;
    logic                   neg_reg;
    logic signed [SUM_W-1:0] num_sel;
    logic [DEN_W-1:0]       nmag;
    logic [DEN_W:0]         shifted;
    logic [DEN_W+1:0]       trial;
    logic [DIVD_W-1:0]      q_sat;
    logic [RESULT_BITS-1:0] comp_val;
    logic [RESULT_BITS-1:0] outv_reg [N_COMP];

    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic                   out_deg_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            in_pos[j] = s_axis_tdata[j*COORD_BITS +: COORD_BITS];
        end
        for (int j = 0; j < 2; j++)
        begin
            in_tex[j] = s_axis_tdata[(3+j)*COORD_BITS +: COORD_BITS];
        end
    end

    // Corners 0 and 1 only; the user must write a corner before it is relied on (not enforced).
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pos_reg[cmd.store_idx][j] <= in_pos[j];
            end
        end
        if (cmd.store)
        begin
            for (int j = 0; j < 2; j++)
            begin
                tex_reg[cmd.store_idx][j] <= in_tex[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tri_start)
        begin
            for (int j = 0; j < 3; j++)
            begin
                e0_reg[j] <= EDGE_W'(pos_reg[1][j]) - EDGE_W'(pos_reg[0][j]);
                e1_reg[j] <= EDGE_W'(in_pos[j]) - EDGE_W'(pos_reg[0][j]);
            end
            du0_reg <= EDGE_W'(tex_reg[1][0]) - EDGE_W'(tex_reg[0][0]);
            dv0_reg <= EDGE_W'(tex_reg[1][1]) - EDGE_W'(tex_reg[0][1]);
            du1_reg <= EDGE_W'(in_tex[0]) - EDGE_W'(tex_reg[0][0]);
            dv1_reg <= EDGE_W'(in_tex[1]) - EDGE_W'(tex_reg[0][1]);
        end
    end

    // Pair 0 is the determinant, pairs 1-3 the tangent numerators and
    // pairs 4-6 the binormal numerators; each pair is first minus second.
    always_comb
    begin
        op_a = du0_reg;
        op_b = dv1_reg;
        case (cmd.mul_step)
            4'd0:  begin op_a = du0_reg;   op_b = dv1_reg; end
            4'd1:  begin op_a = dv0_reg;   op_b = du1_reg; end
            4'd2:  begin op_a = e0_reg[0]; op_b = dv1_reg; end
            4'd3:  begin op_a = e1_reg[0]; op_b = dv0_reg; end
            4'd4:  begin op_a = e0_reg[1]; op_b = dv1_reg; end
            4'd5:  begin op_a = e1_reg[1]; op_b = dv0_reg; end
            4'd6:  begin op_a = e0_reg[2]; op_b = dv1_reg; end
            4'd7:  begin op_a = e1_reg[2]; op_b = dv0_reg; end
            4'd8:  begin op_a = e1_reg[0]; op_b = du0_reg; end
            4'd9:  begin op_a = e0_reg[0]; op_b = du1_reg; end
            4'd10: begin op_a = e1_reg[1]; op_b = du0_reg; end
            4'd11: begin op_a = e0_reg[1]; op_b = du1_reg; end
            4'd12: begin op_a = e1_reg[2]; op_b = du0_reg; end
            4'd13: begin op_a = e0_reg[2]; op_b = du1_reg; end
            default: begin op_a = du0_reg; op_b = dv1_reg; end
        endcase
    end

    assign prev_step = cmd.mul_step - 4'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= op_a * op_b;
            if (cmd.mul_step != 4'd0)
            begin
                if (!prev_step[0])
                begin
                    first_reg <= prod_reg;
                end
                else
                begin
                    res_reg[prev_step[3:1]] <= SUM_W'(first_reg) - SUM_W'(prod_reg);
                end
            end
        end
    end

    assign sts.det_zero = (res_reg[0] == '0);
    assign sts.out_free = !out_valid_reg || m_axis_tready;

    assign num_sel = res_reg[cmd.comp];
    assign nmag    = num_sel[SUM_W-1] ? DEN_W'(-num_sel) : DEN_W'(num_sel);
    assign shifted = {rem_reg, dq_reg[DIVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dmag_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dq_reg   <= {nmag, {QUOT_SHIFT{1'b0}}};
            rem_reg  <= '0;
            dmag_reg <= res_reg[0][SUM_W-1] ? DEN_W'(-res_reg[0]) : DEN_W'(res_reg[0]);
            neg_reg  <= num_sel[SUM_W-1] ^ res_reg[0][SUM_W-1];
        end
        else if (cmd.div_step)
        begin
            if (!trial[DEN_W+1])
            begin
                rem_reg <= trial[DEN_W-1:0];
                dq_reg  <= {dq_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DEN_W-1:0];
                dq_reg  <= {dq_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            q_sat = (dq_reg > MAXPOS_Q + 1'b1) ? MAXPOS_Q + 1'b1 : dq_reg;
            comp_val = RESULT_BITS'(-q_sat);
        end
        else
        begin
            q_sat = (dq_reg > MAXPOS_Q) ? MAXPOS_Q : dq_reg;
            comp_val = RESULT_BITS'(q_sat);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_sat)
        begin
            outv_reg[3'(cmd.comp - 3'd1)] <= comp_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_deg_reg <= sts.det_zero;
            for (int k = 0; k < N_COMP; k++)
            begin
                out_data_reg[k*RESULT_BITS +: RESULT_BITS] <=
                    sts.det_zero ? '0 : outv_reg[k];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_deg_reg;

endmodule

// File: sv/triangle_tangent_basis.sv
`timescale 1ns / 1ps
// Corners 0 and 1 are stored. Corner 2 starts the triangle: the shared
// multiplier forms its 14 products, then the one-bit-per-cycle divider runs
// once per component; input stays not ready until the result is loaded.
// A zero determinant skips the divider.
// Reset (rst_n, asynchronous, active low) clears the controller and output valid.
// ----------------------------------------------------------------------------
// triangle_tangent_basis
// Tangent and binormal of a textured triangle, given one corner per
// transaction, in signed Q15.16 with saturation.
// ----------------------------------------------------------------------------
module triangle_tangent_basis
    import ttb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // corner
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // degenerate
    output logic                  m_axis_tuser
);

    ttb_cmd_t cmd;
    ttb_sts_t sts;

    ttb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser (s_axis_tuser),
        .sts          (sts),
        .cmd          (cmd)
    );

    ttb_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .cmd          (cmd),
        .sts          (sts),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending transaction");

    a_no_div_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !sts.det_zero)
        else $error("divider running on a zero determinant");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul_en || cmd.div_step) |-> !s_axis_tready)
        else $error("input ready while a triangle is in progress");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

endmodule
